FILE: hw/rtl/playfair_digraph_cipher_top_assert.svh
// Assertion macros for the Playfair digraph cipher top level.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define PLF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define PLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/plf_pkg.sv
// Shared types, constants and square lookup functions for the Playfair cipher.
package plf_pkg;

  localparam int SQUARE_SIDE = 5;
  localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int LETTER_W    = 5;
  localparam int POS_W       = $clog2(SQUARE_SIDE);
  localparam int CELL_W      = $clog2(CELLS);
  localparam int SQUARE_W    = CELLS * LETTER_W;
  localparam int CFG_W       = 45;
  localparam int LOW_W       = 45;
  localparam int MID_W       = 40;
  localparam int HIGH_W      = 40;
  localparam int REG_IDX_W   = 2;
  localparam int RES_IDX_W   = 2;

  typedef logic [LETTER_W-1:0]  letter_t;
  typedef logic [SQUARE_W-1:0]  square_t;
  typedef letter_t [1:0]        duo_t;
  typedef letter_t [3:0]        quad_t;

  localparam letter_t FILLER_X = 5'd23;
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_SQUARE_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SQUARE_MID  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SQUARE_HIGH = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIRECTION   = 2'd3;

  localparam logic [RES_IDX_W-1:0] RES_LAST_PAIR = 2'd1;
  localparam logic [RES_IDX_W-1:0] RES_LAST_QUAD = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  typedef struct packed {
    letter_t a;
    letter_t b;
    letter_t c;
    logic    quad;
  } pair_t;

  function automatic logic letters_match(letter_t x, letter_t y);
    return (x == y) || (x == LETTER_I && y == LETTER_J) || (x == LETTER_J && y == LETTER_I);
  endfunction

  function automatic letter_t cell_at(square_t sq, pos_t p);
    logic [CELL_W-1:0] idx;
    idx = CELL_W'(p.row) * CELL_W'(SQUARE_SIDE) + CELL_W'(p.col);
    return sq[idx * LETTER_W +: LETTER_W];
  endfunction

  // First matching cell in row-major order; no match lands on cell 0.
  function automatic pos_t locate(square_t sq, letter_t l);
    pos_t    p;
    logic    found;
    letter_t sq_letter;
    p     = '0;
    found = 1'b0;
    for (int r = 0; r < SQUARE_SIDE; r++) begin
      for (int c = 0; c < SQUARE_SIDE; c++) begin
        sq_letter = sq[(r * SQUARE_SIDE + c) * LETTER_W +: LETTER_W];
        if (!found && letters_match(l, sq_letter)) begin
          found = 1'b1;
          p.row = POS_W'(r);
          p.col = POS_W'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [POS_W-1:0] shift_pos(logic [POS_W-1:0] v, logic dir);
    logic [POS_W-1:0] r;
    if (dir == DIR_DECRYPT) begin
      r = (v == '0) ? POS_W'(SQUARE_SIDE - 1) : v - 1'b1;
    end else begin
      r = (v == POS_W'(SQUARE_SIDE - 1)) ? '0 : v + 1'b1;
    end
    return r;
  endfunction

  function automatic duo_t digraph(square_t sq, logic dir, pos_t pa, pos_t pb);
    pos_t na;
    pos_t nb;
    duo_t d;
    na = pa;
    nb = pb;
    if (pa.row == pb.row) begin
      na.col = shift_pos(pa.col, dir);
      nb.col = shift_pos(pb.col, dir);
    end else if (pa.col == pb.col) begin
      na.row = shift_pos(pa.row, dir);
      nb.row = shift_pos(pb.row, dir);
    end else begin
      na.col = pb.col;
      nb.col = pa.col;
    end
    d[0] = cell_at(sq, na);
    d[1] = cell_at(sq, nb);
    return d;
  endfunction

endpackage

FILE: hw/rtl/plf_stream_if.sv
// Valid/ready stream interfaces for input letters and result letters.
interface plf_in_if;
  logic                          valid;
  logic                          ready;
  logic [plf_pkg::LETTER_W-1:0]  letter_in;
  logic                          final_in;

  modport source (output valid, output letter_in, output final_in, input ready);
  modport sink   (input valid, input letter_in, input final_in, output ready);
endinterface

interface plf_out_if;
  logic                          valid;
  logic                          ready;
  logic [plf_pkg::LETTER_W-1:0]  letter_out;
  logic                          final_out;

  modport source (output valid, output letter_out, output final_out, input ready);
  modport sink   (input valid, input letter_out, input final_out, output ready);
endinterface

FILE: hw/rtl/plf_front.sv
// Digraph builder: pending letter, filler insertion and the input pair register.
module plf_front (
  input  logic           clk,
  input  logic           rst,
  plf_in_if.sink         din,
  input  logic           take,
  output logic           pair_valid,
  output plf_pkg::pair_t pair
);
  import plf_pkg::*;

  letter_t held_letter;
  letter_t held_letter_next;
  logic    held_valid;
  logic    held_valid_next;
  logic    load;
  logic    accept;
  logic    same;
  pair_t   pair_next;

  assign din.ready = !pair_valid || take;
  assign accept    = din.valid && din.ready;
  assign same      = letters_match(held_letter, din.letter_in);

  always_comb begin
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    load             = 1'b0;
    pair_next.a      = held_letter;
    pair_next.b      = din.letter_in;
    pair_next.c      = din.letter_in;
    pair_next.quad   = 1'b0;
    if (!held_valid) begin
      pair_next.a = din.letter_in;
      pair_next.b = FILLER_X;
      if (din.final_in) begin
        load = 1'b1;
      end else begin
        held_letter_next = din.letter_in;
        held_valid_next  = 1'b1;
      end
    end else if (!same) begin
      load             = 1'b1;
      held_valid_next  = 1'b0;
      held_letter_next = '0;
    end else begin
      pair_next.b    = FILLER_X;
      pair_next.quad = din.final_in;
      load           = 1'b1;
      if (din.final_in) begin
        held_valid_next  = 1'b0;
        held_letter_next = '0;
      end else begin
        held_letter_next = din.letter_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_letter <= '0;
      pair_valid  <= 1'b0;
    end else begin
      if (accept) begin
        held_valid  <= held_valid_next;
        held_letter <= held_letter_next;
      end
      if (accept && load) begin
        pair_valid <= 1'b1;
      end else if (take) begin
        pair_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load) begin
      pair <= pair_next;
    end
  end

endmodule

FILE: hw/rtl/plf_subst.sv
// Key-square substitution of the first digraph and the trailing padded digraph.
module plf_subst (
  input  logic             [plf_pkg::SQUARE_W-1:0] square,
  input  logic             direction,
  input  plf_pkg::pair_t   pair,
  output plf_pkg::quad_t   result
);
  import plf_pkg::*;

  pos_t pa;
  pos_t pb;
  pos_t pc;
  duo_t d0;
  duo_t d1;

  // b is the filler whenever a second digraph exists
  assign pa = locate(square, pair.a);
  assign pb = locate(square, pair.b);
  assign pc = locate(square, pair.c);
  assign d0 = digraph(square, direction, pa, pb);
  assign d1 = digraph(square, direction, pc, pb);

  assign result[0] = d0[0];
  assign result[1] = d0[1];
  assign result[2] = d1[0];
  assign result[3] = d1[1];

endmodule

FILE: hw/rtl/plf_drain.sv
// Result register that hands out two or four letters one transaction at a time.
module plf_drain (
  input  logic           clk,
  input  logic           rst,
  input  logic           pair_valid,
  input  logic           quad_in,
  input  plf_pkg::quad_t quad_data,
  output logic           take,
  plf_out_if.source      dout
);
  import plf_pkg::*;

  quad_t                letters;
  logic                 quad;
  logic [RES_IDX_W-1:0] idx;
  logic                 res_valid;
  logic                 last;
  logic                 fire;

  assign last = (idx == (quad ? RES_LAST_QUAD : RES_LAST_PAIR));
  assign fire = dout.valid && dout.ready;
  assign take = pair_valid && (!res_valid || (fire && last));

  assign dout.valid      = res_valid;
  assign dout.letter_out = letters[idx];
  assign dout.final_out  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      res_valid <= 1'b1;
      idx       <= '0;
    end else if (fire) begin
      if (last) begin
        res_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      letters <= quad_data;
      quad    <= quad_in;
    end
  end

endmodule

FILE: hw/rtl/playfair_digraph_cipher_top.sv
// Top level of the streaming Playfair digraph cipher.
// Letters enter on din one transaction per cycle while the pair register is free; the pending
// letter and filler X are handled at entry, the key-square lookup sits between the pair
// register and the result register, and results leave on dout one letter per cycle while dout
// is ready. Each digraph yields two results, and a letter that repeats the pending one gets
// its own filler digraph; a final letter that repeats the pending one yields four results.
// The digraph that a transaction completes is held in the pair register and then in the
// result register, which it enters once that register is free, before it is presented.
// Configuration (square_low, square_mid, square_high, direction at indexes 0 to 3) must be
// written by the user while idle; the block itself does not enforce it.
`include "playfair_digraph_cipher_top_assert.svh"

module playfair_digraph_cipher_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [plf_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [plf_pkg::CFG_W-1:0]      wr_data,
  plf_in_if.sink                         din,
  plf_out_if.source                      dout
);
  import plf_pkg::*;

  logic [LOW_W-1:0]  square_low;
  logic [MID_W-1:0]  square_mid;
  logic [HIGH_W-1:0] square_high;
  logic              direction;
  square_t           square;
  pair_t             pair;
  logic              pair_valid;
  logic              pair_take;
  quad_t             subst_out;

  assign square = {square_high, square_mid, square_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      square_low  <= '0;
      square_mid  <= '0;
      square_high <= '0;
      direction   <= DIR_ENCRYPT;
    end else if (wr_en) begin
      case (wr_index)
        REG_SQUARE_LOW:  square_low  <= wr_data[LOW_W-1:0];
        REG_SQUARE_MID:  square_mid  <= wr_data[MID_W-1:0];
        REG_SQUARE_HIGH: square_high <= wr_data[HIGH_W-1:0];
        REG_DIRECTION:   direction   <= wr_data[0];
        default: ;
      endcase
    end
  end

  plf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .take       (pair_take),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  plf_subst u_subst (
    .square    (square),
    .direction (direction),
    .pair      (pair),
    .result    (subst_out)
  );

  plf_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .quad_in    (pair.quad),
    .quad_data  (subst_out),
    .take       (pair_take),
    .dout       (dout)
  );

  `PLF_ASSERT_IMPLY(a_ready_when_free, !pair_valid, din.ready, "input stalled with pair reg free")
  `PLF_ASSERT_NEXT(a_take_shows_result, pair_take, dout.valid, "taken pair not presented")
  `PLF_ASSERT_IMPLY(a_no_overwrite, pair_take && dout.valid, dout.ready && dout.final_out, "result overwritten")

endmodule
